// File: rtl/srpd_pkg.sv
`default_nettype none

package srpd_pkg;

    // Field widths
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned GROUP_W = 7;
    localparam int unsigned ID_W    = 7;
    localparam int unsigned CODE_W  = 5;
    localparam int unsigned VALUE_W = 28;
    localparam int unsigned IDX_W   = 3;
    localparam int unsigned GEAR_W  = 2 * GROUP_W;

    // Packet framing
    localparam logic [IDX_W-1:0] MIN_LENGTH = 3'd4;
    localparam logic [IDX_W-1:0] IDX_START  = 3'd0;
    localparam logic [IDX_W-1:0] IDX_HEADER = 3'd1;
    localparam logic [IDX_W-1:0] IDX_FIRST  = 3'd2;
    localparam logic [IDX_W-1:0] IDX_SECOND = 3'd3;

    // Reply codes
    localparam logic [CODE_W-1:0] CODE_SHORT_LO = 5'h10;
    localparam logic [CODE_W-1:0] CODE_SHORT_HI = 5'h17;
    localparam logic [CODE_W-1:0] CODE_GEAR     = 5'h18;
    localparam logic [CODE_W-1:0] CODE_SHORT_A  = 5'h19;
    localparam logic [CODE_W-1:0] CODE_SHORT_B  = 5'h1a;
    localparam logic [CODE_W-1:0] CODE_POSITION = 5'h1b;
    localparam logic [CODE_W-1:0] CODE_TORQUE   = 5'h1e;

    // Value decode kinds
    localparam logic [1:0] KIND_NONE   = 2'd0;
    localparam logic [1:0] KIND_SHORT  = 2'd1;
    localparam logic [1:0] KIND_GEAR   = 2'd2;
    localparam logic [1:0] KIND_SIGNED = 2'd3;

    typedef struct packed {
        logic [ID_W-1:0]           drive_id;
        logic [CODE_W-1:0]         reply_code;
        logic signed [VALUE_W-1:0] reply_value;
    } srpd_result_t;

    typedef struct packed {
        logic         valid;
        srpd_result_t result;
    } srpd_frm_out_t;

    function automatic logic [1:0] code_kind(input logic [CODE_W-1:0] code);
        logic [1:0] kind;
        case (code) inside
            [CODE_SHORT_LO:CODE_SHORT_HI], CODE_SHORT_A, CODE_SHORT_B: kind = KIND_SHORT;
            CODE_GEAR:                                                 kind = KIND_GEAR;
            CODE_POSITION, CODE_TORQUE:                                kind = KIND_SIGNED;
            default:                                                   kind = KIND_NONE;
        endcase
        return kind;
    endfunction

endpackage

`default_nettype wire

// File: rtl/srpd_byte_if.sv
`default_nettype none

interface srpd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

// File: rtl/srpd_reply_if.sv
`default_nettype none

interface srpd_reply_if;
    logic               valid;
    logic               ready;
    logic [6:0]         drive_id;
    logic [4:0]         reply_code;
    logic signed [27:0] reply_value;

    modport source (output valid, output drive_id, output reply_code, output reply_value,
                    input ready);
    modport sink (input valid, input drive_id, input reply_code, input reply_value,
                  output ready);
endinterface

`default_nettype wire

// File: rtl/srpd_in_stage.sv
`default_nettype none

module srpd_in_stage
    import srpd_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    srpd_byte_if.sink              rx,
    input  wire logic              advance,
    output logic                   byte_valid,
    output logic [BYTE_W-1:0]      byte_data
);

    logic              valid_reg;
    logic              valid_next;
    logic [BYTE_W-1:0] data_reg;
    logic              take;

    // Register is free when empty or being consumed this cycle
    assign rx.ready   = !valid_reg || advance;
    assign take       = rx.valid && rx.ready;
    assign valid_next = take ? 1'b1 : (valid_reg && !advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            data_reg <= rx.rx_byte;
        end
    end

    assign byte_valid = valid_reg;
    assign byte_data  = data_reg;

endmodule

`default_nettype wire

// File: rtl/srpd_framer.sv
`default_nettype none

module srpd_framer
    import srpd_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              step,
    input  wire logic [BYTE_W-1:0] byte_data,
    output srpd_frm_out_t          frm_out
);

    logic                  in_packet_reg, in_packet_next;
    logic [IDX_W-1:0]      idx_reg, idx_next;
    logic [IDX_W-1:0]      len_reg, len_next;
    logic [ID_W-1:0]       id_reg, id_next;
    logic [CODE_W-1:0]     code_reg, code_next;
    logic [GROUP_W-1:0]    sum_reg, sum_next;
    logic [VALUE_W-1:0]    acc_reg, acc_next;
    logic [GEAR_W-1:0]     ftg_reg, ftg_next;

    logic [GROUP_W-1:0]    grp;
    logic [1:0]            kind;
    logic [IDX_W:0]        idx_plus;

    assign grp      = byte_data[GROUP_W-1:0];
    assign kind     = code_kind(code_reg);
    assign idx_plus = {1'b0, idx_reg} + {{IDX_W{1'b0}}, 1'b1};

    // Per-byte framing update
    always_comb
    begin
        in_packet_next = in_packet_reg;
        idx_next       = idx_reg;
        len_next       = len_reg;
        id_next        = id_reg;
        code_next      = code_reg;
        sum_next       = sum_reg;
        acc_next       = acc_reg;
        ftg_next       = ftg_reg;
        frm_out        = '0;

        if (!in_packet_reg)
        begin
            // hunting: bit 7 clear marks the start byte
            if (!byte_data[BYTE_W-1])
            begin
                in_packet_next = 1'b1;
                id_next        = grp;
                sum_next       = grp;
                idx_next       = IDX_HEADER;
            end
        end
        else if (idx_reg == IDX_HEADER)
        begin
            len_next  = MIN_LENGTH + {1'b0, byte_data[6:5]};
            code_next = byte_data[CODE_W-1:0];
            sum_next  = sum_reg + grp;
            idx_next  = IDX_FIRST;
        end
        else
        begin
            // first two value groups, kept for short and gear replies
            if (idx_reg == IDX_FIRST)
            begin
                ftg_next = {grp, {GROUP_W{1'b0}}};
            end
            else if (idx_reg == IDX_SECOND)
            begin
                ftg_next = {ftg_reg[GEAR_W-1:GROUP_W], grp};
            end

            if (idx_plus < {1'b0, len_reg})
            begin
                // data byte
                if (idx_reg == IDX_FIRST)
                begin
                    acc_next = {{(VALUE_W-GROUP_W){grp[GROUP_W-1]}}, grp};
                end
                else
                begin
                    acc_next = {acc_reg[VALUE_W-GROUP_W-1:0], grp};
                end
                sum_next = sum_reg + grp;
                idx_next = idx_plus[IDX_W-1:0];
            end
            else
            begin
                // checksum byte
                in_packet_next = 1'b0;
                idx_next       = IDX_START;
                if (byte_data == {1'b1, sum_reg} && kind != KIND_NONE)
                begin
                    frm_out.valid             = 1'b1;
                    frm_out.result.drive_id   = id_reg;
                    frm_out.result.reply_code = code_reg;
                    case (kind)
                        KIND_SHORT:
                            frm_out.result.reply_value =
                                {{(VALUE_W-GROUP_W){1'b0}}, ftg_next[GEAR_W-1:GROUP_W]};
                        KIND_GEAR:
                            frm_out.result.reply_value =
                                {{(VALUE_W-GEAR_W){1'b0}}, ftg_next};
                        default:
                            frm_out.result.reply_value = acc_reg;
                    endcase
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_packet_reg <= 1'b0;
            idx_reg       <= IDX_START;
            len_reg       <= MIN_LENGTH;
            id_reg        <= '0;
            code_reg      <= '0;
            sum_reg       <= '0;
            acc_reg       <= '0;
            ftg_reg       <= '0;
        end
        else if (step)
        begin
            in_packet_reg <= in_packet_next;
            idx_reg       <= idx_next;
            len_reg       <= len_next;
            id_reg        <= id_next;
            code_reg      <= code_next;
            sum_reg       <= sum_next;
            acc_reg       <= acc_next;
            ftg_reg       <= ftg_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/srpd_out_stage.sv
`default_nettype none

module srpd_out_stage
    import srpd_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          load,
    input  wire srpd_frm_out_t frm_out,
    srpd_reply_if.source       reply,
    output logic               busy
);

    logic         valid_reg;
    logic         valid_next;
    srpd_result_t res_reg;

    // Slot is reloaded on every load (emptied if no result); otherwise it drains on transfer
    assign valid_next = load ? frm_out.valid : (valid_reg && !reply.ready);
    assign busy       = valid_reg && !reply.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && frm_out.valid)
        begin
            res_reg <= frm_out.result;
        end
    end

    assign reply.valid       = valid_reg;
    assign reply.drive_id    = res_reg.drive_id;
    assign reply.reply_code  = res_reg.reply_code;
    assign reply.reply_value = res_reg.reply_value;

endmodule

`default_nettype wire

// File: rtl/servo_reply_packet_deframer_core.sv
// Pipeline: a transferred byte waits in the input register until the framer steps; a
//   result it completes is loaded into the result register in that step (two register stages).
// Throughput: one byte per cycle; a waiting result stalls the framer only
//   until it is transferred (input register and result register).
// Reset: rst_n asynchronous, active low; the framer returns to hunting.
`default_nettype none

module servo_reply_packet_deframer_core
    import srpd_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    srpd_byte_if.sink    rx,
    srpd_reply_if.source reply
);

    logic              byte_valid;
    logic [BYTE_W-1:0] byte_data;
    logic              advance;
    logic              busy;
    srpd_frm_out_t     frm_out;

    // Framer steps when a byte is held and the result slot is free
    assign advance = byte_valid && !busy;

    srpd_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .rx         (rx),
        .advance    (advance),
        .byte_valid (byte_valid),
        .byte_data  (byte_data)
    );

    srpd_framer u_framer (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .byte_data (byte_data),
        .frm_out   (frm_out)
    );

    srpd_out_stage u_out_stage (
        .clk     (clk),
        .rst_n   (rst_n),
        .load    (advance),
        .frm_out (frm_out),
        .reply   (reply),
        .busy    (busy)
    );

    // Checks
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        advance |-> !(reply.valid && !reply.ready))
        else $error("result overwritten before transfer");

    a_known_code: assert property (@(posedge clk) disable iff (!rst_n)
        reply.valid |-> code_kind(reply.reply_code) != KIND_NONE)
        else $error("result with unknown reply code");

    a_short_range: assert property (@(posedge clk) disable iff (!rst_n)
        (reply.valid && code_kind(reply.reply_code) == KIND_SHORT)
            |-> reply.reply_value[VALUE_W-1:GROUP_W] == '0)
        else $error("short value wider than one group");

    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !byte_valid |-> rx.ready)
        else $error("empty input register not ready");

endmodule

`default_nettype wire

// File: test/tb_servo_reply_packet_deframer_core.sv
`default_nettype none

module tb_servo_reply_packet_deframer_core;
    timeunit 1ns;
    timeprecision 1ps;

    import srpd_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 10;
    localparam logic [CODE_W-1:0] CODE_UNKNOWN = 5'h1f;

    // Tracks the framer state byte by byte and queues the replies it should emit
    class deframe_scoreboard;
        bit                 in_packet;
        logic [IDX_W-1:0]   byte_index;
        logic [IDX_W-1:0]   frame_len;
        logic [ID_W-1:0]    held_id;
        logic [CODE_W-1:0]  held_code;
        logic [GROUP_W-1:0] byte_sum;
        logic [VALUE_W-1:0] group_acc;
        logic [GEAR_W-1:0]  head_groups;
        srpd_result_t       due_replies[$];

        function new();
            in_packet   = 1'b0;
            byte_index  = IDX_START;
            frame_len   = MIN_LENGTH;
            held_id     = '0;
            held_code   = '0;
            byte_sum    = '0;
            group_acc   = '0;
            head_groups = '0;
        endfunction

        function void note_rx_byte(logic [BYTE_W-1:0] b);
            logic [GROUP_W-1:0] g;
            srpd_result_t       r;
            g = b[GROUP_W-1:0];

            // hunting: only a byte with the top bit clear opens a packet
            if (!in_packet)
            begin
                if (!b[7])
                begin
                    in_packet  = 1'b1;
                    held_id    = g;
                    byte_sum   = g;
                    byte_index = IDX_HEADER;
                end
                return;
            end

            // header: xLLFFFFF (top bit not checked)
            if (byte_index == IDX_HEADER)
            begin
                frame_len  = MIN_LENGTH + b[6:5];
                held_code  = b[4:0];
                byte_sum   = byte_sum + g;
                byte_index = IDX_FIRST;
                return;
            end

            if (byte_index == IDX_FIRST)
                head_groups = {g, 7'd0};
            else if (byte_index == IDX_SECOND)
                head_groups[GROUP_W-1:0] = g;

            // data byte, any value
            if (int'(byte_index) + 1 < int'(frame_len))
            begin
                if (byte_index == IDX_FIRST)
                    group_acc = {{(VALUE_W-GROUP_W){g[6]}}, g};
                else
                    group_acc = {group_acc[VALUE_W-GROUP_W-1:0], g};
                byte_sum   = byte_sum + g;
                byte_index = byte_index + 1'b1;
                return;
            end

            // checksum byte closes the packet
            in_packet  = 1'b0;
            byte_index = IDX_START;
            if (b !== {1'b1, byte_sum})
                return;
            r.drive_id   = held_id;
            r.reply_code = held_code;
            if ((held_code >= CODE_SHORT_LO && held_code <= CODE_SHORT_HI) ||
                held_code == CODE_SHORT_A || held_code == CODE_SHORT_B)
                r.reply_value = {{(VALUE_W-GROUP_W){1'b0}}, head_groups[GEAR_W-1:GROUP_W]};
            else if (held_code == CODE_GEAR)
                r.reply_value = {{(VALUE_W-GEAR_W){1'b0}}, head_groups};
            else if (held_code == CODE_POSITION || held_code == CODE_TORQUE)
                r.reply_value = group_acc;
            else
                return;
            due_replies.push_back(r);
        endfunction

        function string check_reply(srpd_result_t got);
            srpd_result_t want;
            string        msg;
            if (due_replies.size() == 0)
                return $sformatf("reply with nothing due: id %0h code %0h value %0d",
                                 got.drive_id, got.reply_code, got.reply_value);
            want = due_replies.pop_front();
            msg  = "";
            if (got.drive_id !== want.drive_id)
                msg = {msg, $sformatf(" drive_id %0h/%0h", got.drive_id, want.drive_id)};
            if (got.reply_code !== want.reply_code)
                msg = {msg, $sformatf(" reply_code %0h/%0h", got.reply_code, want.reply_code)};
            if (got.reply_value !== want.reply_value)
                msg = {msg, $sformatf(" reply_value %0d/%0d", got.reply_value,
                                      want.reply_value)};
            if (msg != "")
                msg = {"reply mismatch (got/want):", msg};
            return msg;
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    srpd_byte_if  rx_if ();
    srpd_reply_if reply_if ();

    servo_reply_packet_deframer_core u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx_if),
        .reply (reply_if)
    );

    deframe_scoreboard sb;
    logic [BYTE_W-1:0] stim_bytes[$];
    int                packet_bytes;
    int                mismatches;
    int                idle_cycles;
    int                hold_left;
    int                stall_left;
    bit                tx_calm;
    bit                rx_calm;
    bit                hold_req;
    bit                hold_taken;
    srpd_result_t      seen_reply;
    string             check_msg;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("%0t ERROR %s", $time, msg);
    endtask

    // queue one packet; data bytes are taken from the low end of data first
    function automatic void add_packet(logic [ID_W-1:0] id, logic [BYTE_W-1:0] header,
                                       logic [31:0] data, bit bad_sum);
        int                 len;
        logic [GROUP_W-1:0] sum;
        logic [BYTE_W-1:0]  b;
        len = 4 + header[6:5];
        sum = id + header[GROUP_W-1:0];
        stim_bytes.push_back({1'b0, id});
        stim_bytes.push_back(header);
        for (int i = 0; i < len - 3; i++)
        begin
            b   = data[8*i +: 8];
            sum = sum + b[GROUP_W-1:0];
            stim_bytes.push_back(b);
        end
        b = {1'b1, sum};
        if (bad_sum)
            b = b ^ 8'($urandom_range(1, 255));
        stim_bytes.push_back(b);
        packet_bytes += len;
    endfunction

    function automatic void add_random_item();
        int                r;
        int                k;
        logic [CODE_W-1:0] code;
        logic [BYTE_W-1:0] header;
        r = $urandom_range(0, 99);
        // stray line noise, mostly bytes the hunter drops
        if (r < 8)
        begin
            if ($urandom_range(0, 3) == 0)
                stim_bytes.push_back(8'($urandom_range(0, 255)));
            else
                stim_bytes.push_back(8'($urandom_range(128, 255)));
            return;
        end
        k = $urandom_range(0, 9);
        if (k < 3)
        begin
            k = $urandom_range(0, 9);
            if (k < 8)
                code = CODE_SHORT_LO + CODE_W'(k);
            else if (k == 8)
                code = CODE_SHORT_A;
            else
                code = CODE_SHORT_B;
        end
        else if (k < 5)
            code = CODE_GEAR;
        else if (k < 7)
            code = CODE_POSITION;
        else if (k < 9)
            code = CODE_TORQUE;
        else
            code = 5'($urandom_range(0, 31));
        header = {($urandom_range(0, 3) != 0), 2'($urandom_range(0, 3)), code};
        add_packet(7'($urandom_range(0, 127)), header, $urandom(), r < 18);
    endfunction

    // offer one byte from a falling edge, return on a falling edge
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        int gap;
        rx_if.valid   <= 1'b1;
        rx_if.rx_byte <= b;
        @(posedge clk);
        while (!rx_if.ready)
            @(posedge clk);
        sb.note_rx_byte(b);
        @(negedge clk);
        gap = tx_calm ? 0 : pick_gap();
        if (gap > 0)
        begin
            rx_if.valid   <= 1'b0;
            rx_if.rx_byte <= 8'($urandom_range(0, 255));
            repeat (gap) @(negedge clk);
        end
    endtask

    task automatic flush_bytes();
        while (stim_bytes.size() > 0)
            send_byte(stim_bytes.pop_front());
    endtask

    // sender idles until every due reply has been transferred
    task automatic wait_for_drain();
        rx_if.valid <= 1'b0;
        while (sb.due_replies.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic run_random(input int target);
        while (packet_bytes < target)
        begin
            add_random_item();
            flush_bytes();
        end
    endtask

    // reply ready with random stalls and a requested long hold-off
    initial
    begin
        hold_left      = 0;
        stall_left     = 0;
        hold_taken     = 1'b0;
        reply_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req && !hold_taken)
            begin
                hold_left  = HOLD_CYCLES;
                hold_taken = 1'b1;
            end
            if (hold_left > 0)
            begin
                reply_if.ready <= 1'b0;
                hold_left--;
            end
            else if (rx_calm)
                reply_if.ready <= 1'b1;
            else if (stall_left > 0)
            begin
                reply_if.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                reply_if.ready <= 1'b1;
                stall_left = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
            end
        end
    end

    // check each reply transfer
    always @(posedge clk)
    begin
        if (rst_n && reply_if.valid && reply_if.ready)
        begin
            seen_reply.drive_id    = reply_if.drive_id;
            seen_reply.reply_code  = reply_if.reply_code;
            seen_reply.reply_value = reply_if.reply_value;
            check_msg = sb.check_reply(seen_reply);
            if (check_msg != "")
                report_mismatch(check_msg);
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((rx_if.valid && rx_if.ready) || (reply_if.valid && reply_if.ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb_servo_reply_packet_deframer_core failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        rx_if.valid    = 1'b0;
        rx_if.rx_byte  = '0;
        rst_n          = 1'b0;
        tx_calm        = 1'b0;
        rx_calm        = 1'b0;
        hold_req       = 1'b0;
        packet_bytes   = 0;
        mismatches     = 0;
        sb = new();

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed packets
        stim_bytes.push_back(8'hFF);                                          // dropped while hunting
        add_packet(7'h7F, {1'b1, 2'd0, CODE_GEAR}, 32'h0000_007F, 1'b0);      // gear, checksum is low group
        add_packet(7'h00, {1'b1, 2'd0, CODE_SHORT_LO}, 32'h0000_0000, 1'b0);  // data looks like a start byte
        add_packet(7'h2A, {1'b1, 2'd3, CODE_POSITION}, 32'hFFFF_FF3F, 1'b0);  // largest positive value
        add_packet(7'h55, {1'b1, 2'd3, CODE_TORQUE}, 32'h0000_0040, 1'b0);    // most negative value
        add_packet(7'h01, {1'b0, 2'd0, CODE_SHORT_HI}, 32'h0000_0055, 1'b1);  // bad checksum
        add_packet(7'h7E, {1'b1, 2'd0, CODE_UNKNOWN}, 32'h0000_0012, 1'b0);   // unknown reply code
        flush_bytes();

        run_random(300);
        wait_for_drain();

        // no idling on either side
        tx_calm = 1'b1;
        rx_calm = 1'b1;
        run_random(450);
        rx_calm = 1'b0;

        // receiver holds off while the sender keeps offering at full rate
        hold_req = 1'b1;
        run_random(560);
        tx_calm = 1'b0;
        wait_for_drain();

        run_random(900);
        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && sb.due_replies.size() == 0)
            $display("tb_servo_reply_packet_deframer_core passed");
        else
            $display("tb_servo_reply_packet_deframer_core failed");
        $finish;
    end

endmodule

`default_nettype wire
